// File: src/ile_pkg.sv
// Shared types, field widths and constants for the indexed list engine.
package ile_pkg;

   // Default list depth
   localparam int DEF_CAPACITY = 1024;

   // Field widths of the request and response words
   localparam int CMD_W   = 3;
   localparam int POS_W   = 11;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 11;

   // Packed bus widths, padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // Read result when nothing was read
   localparam logic [VALUE_W-1:0] NONE_VALUE = '1;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_HEAD   = 3'd1,
      CMD_TAIL   = 3'd2,
      CMD_AT     = 3'd3,
      CMD_DELETE = 3'd4
   } cmd_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DRAIN,
      ST_PLACE,
      ST_RDWAIT,
      ST_FINISH
   } state_type;

endpackage

// File: src/ile_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/indexed_list_engine_top.sv
// Indexed list engine: ordered list in a RAM, shifted one entry per cycle.
// A read goes through the read-wait and finish states; an insert shifts the entries above
//   its position through shift, drain and place (place alone at the tail), a delete shifts
//   through shift and drain (straight to finish when nothing moves); a refused or unknown
//   command goes straight to finish. One word is in flight at a time; the single RAM port
//   pair moves one entry per cycle.
// Reset (synchronous, active high) empties the list; store contents are not cleared.
module indexed_list_engine_top #(
   parameter int CAPACITY = ile_pkg::DEF_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: command[2:0], position[13:3], value[45:14], zero pad
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ile_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: read_value[31:0], found[32], applied[33], length[44:34], zero pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ile_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // Request fields
   logic [ile_pkg::CMD_W-1:0]   req_command;
   logic [ile_pkg::POS_W-1:0]   req_position;
   logic [ile_pkg::VALUE_W-1:0] req_value;

   assign req_command  = req_tdata[2:0];
   assign req_position = req_tdata[13:3];
   assign req_value    = req_tdata[45:14];

   ile_pkg::state_type state_ff, state_in;

   logic [CW-1:0]               count_ff;
   logic [AW-1:0]               src_ff;
   logic [AW-1:0]               end_ff;
   logic [AW-1:0]               place_ff;
   logic                        dir_ff;      // 1: insert (move up), 0: delete (move down)
   logic                        pend_ff;
   logic [AW-1:0]               pend_addr_ff;
   logic [ile_pkg::VALUE_W-1:0] val_ff;
   logic [ile_pkg::VALUE_W-1:0] rdval_ff;
   logic                        found_ff;
   logic                        applied_ff;

   logic                        rsp_valid_ff;
   logic [ile_pkg::VALUE_W-1:0] out_value_ff;
   logic                        out_found_ff;
   logic                        out_applied_ff;
   logic [ile_pkg::LEN_W-1:0]   out_length_ff;

   // RAM controls
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [ile_pkg::VALUE_W-1:0] ram_wdata;
   logic [AW-1:0]               ram_raddr;
   logic [ile_pkg::VALUE_W-1:0] ram_rdata;
   logic                        out_load;

   // Command decode
   logic            accept;
   logic [CMPW-1:0] pos_x;
   logic [CMPW-1:0] cnt_x;
   logic            has_room;
   logic            rd_ok;
   logic            ins_cmd;
   logic            ins_ok;
   logic            del_ok;
   logic [CW-1:0]   ins_pos;
   logic            ins_shift;
   logic            del_shift;
   logic [AW-1:0]   dst_addr;

   assign accept   = req_tvalid && req_tready;
   assign pos_x    = CMPW'(req_position);
   assign cnt_x    = CMPW'(count_ff);
   assign has_room = count_ff < CAP_C;
   assign rd_ok    = (req_command == ile_pkg::CMD_READ) && (pos_x < cnt_x);
   assign del_ok   = (req_command == ile_pkg::CMD_DELETE) && (pos_x < cnt_x);

   // Pick the insert position and check it
   always_comb begin
      ins_cmd = 1'b0;
      ins_pos = '0;
      ins_ok  = 1'b0;
      case (req_command)
         ile_pkg::CMD_HEAD: begin
            ins_cmd = 1'b1;
            ins_ok  = has_room;
         end
         ile_pkg::CMD_TAIL: begin
            ins_cmd = 1'b1;
            ins_pos = count_ff;
            ins_ok  = has_room;
         end
         ile_pkg::CMD_AT: begin
            ins_cmd = 1'b1;
            ins_pos = CW'(pos_x);
            ins_ok  = has_room && (pos_x <= cnt_x);
         end
         default: begin
            ins_cmd = 1'b0;
         end
      endcase
   end

   assign ins_shift = ins_pos != count_ff;
   assign del_shift = (pos_x + CMPW'(1)) < cnt_x;
   assign dst_addr  = dir_ff ? (src_ff + AW'(1)) : (src_ff - AW'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ile_pkg::ST_IDLE: begin
            if (accept) begin
               if (rd_ok) begin
                  state_in = ile_pkg::ST_RDWAIT;
               end else if (ins_cmd && ins_ok) begin
                  state_in = ins_shift ? ile_pkg::ST_SHIFT : ile_pkg::ST_PLACE;
               end else if (del_ok && del_shift) begin
                  state_in = ile_pkg::ST_SHIFT;
               end else begin
                  state_in = ile_pkg::ST_FINISH;
               end
            end
         end
         ile_pkg::ST_SHIFT: begin
            if (src_ff == end_ff) begin
               state_in = ile_pkg::ST_DRAIN;
            end
         end
         ile_pkg::ST_DRAIN: begin
            state_in = dir_ff ? ile_pkg::ST_PLACE : ile_pkg::ST_FINISH;
         end
         ile_pkg::ST_PLACE: begin
            state_in = ile_pkg::ST_FINISH;
         end
         ile_pkg::ST_RDWAIT: begin
            state_in = ile_pkg::ST_FINISH;
         end
         ile_pkg::ST_FINISH: begin
            if (out_load) begin
               state_in = ile_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ile_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: handshake and RAM port controls
   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = pend_addr_ff;
      ram_wdata  = ram_rdata;
      ram_raddr  = src_ff;
      unique case (state_ff)
         ile_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_raddr  = AW'(req_position);
         end
         ile_pkg::ST_SHIFT: begin
            ram_we = pend_ff;
         end
         ile_pkg::ST_DRAIN: begin
            ram_we = pend_ff;
         end
         ile_pkg::ST_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = place_ff;
            ram_wdata = val_ff;
         end
         ile_pkg::ST_RDWAIT: begin
            ram_we = 1'b0;
         end
         ile_pkg::ST_FINISH: begin
            out_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ile_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // Update the length when the command is taken
         if (accept) begin
            if (ins_cmd && ins_ok) begin
               count_ff <= count_ff + CW'(1);
            end else if (del_ok) begin
               count_ff <= count_ff - CW'(1);
            end
         end
         // Track the read in flight during a shift
         pend_ff <= (state_ff == ile_pkg::ST_SHIFT);
         // Hold the result until it is taken
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the current command
   always_ff @(posedge clock) begin
      if (accept) begin
         val_ff     <= req_value;
         place_ff   <= AW'(ins_pos);
         dir_ff     <= ins_cmd;
         rdval_ff   <= ile_pkg::NONE_VALUE;
         found_ff   <= rd_ok;
         applied_ff <= (ins_cmd && ins_ok) || del_ok;
         if (ins_cmd) begin
            src_ff <= AW'(count_ff - CW'(1));
            end_ff <= AW'(ins_pos);
         end else begin
            src_ff <= AW'(pos_x + CMPW'(1));
            end_ff <= AW'(count_ff - CW'(1));
         end
      end else if (state_ff == ile_pkg::ST_SHIFT) begin
         // Advance the source pointer and remember where its data goes
         pend_addr_ff <= dst_addr;
         src_ff       <= dir_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
      end else if (state_ff == ile_pkg::ST_RDWAIT) begin
         rdval_ff <= ram_rdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff   <= rdval_ff;
         out_found_ff   <= found_ff;
         out_applied_ff <= applied_ff;
         out_length_ff  <= ile_pkg::LEN_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_length_ff, out_applied_ff, out_found_ff, out_value_ff};

   ile_ram #(
      .WIDTH(ile_pkg::VALUE_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

`ifndef SYNTH
   // The length never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("list length beyond capacity");

   // The store is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ile_pkg::ST_IDLE) |-> !ram_we)
      else $error("store written while idle");

   // The length moves only when a command is taken
   a_count_on_accept: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(accept))
      else $error("length changed without a command");

   // A new result appears only out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ile_pkg::ST_FINISH))
      else $error("result raised outside finish");

   // A result never reports both a read hit and a list change
   a_found_applied: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_found_ff && out_applied_ff))
      else $error("found and applied both set");
`endif

endmodule
